// File: rtl/core/periodic_window_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Periodic window scheduler assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_WINDOW_SCHEDULER_MACROS_SVH
`define PERIODIC_WINDOW_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic window scheduler package
// Register indexes and sequencer state types shared by the scheduler.
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_START = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_STOP  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_UPDATE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WAS_RUNNING = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIX_INIT,
        ST_ADV,
        ST_DIV,
        ST_SPAN,
        ST_APPLY,
        ST_FIX_NOW,
        ST_FIX_START,
        ST_REG_STOP,
        ST_REG_START,
        ST_DONE
    } pws_state_t;

    // Where the sequencer resumes after a window advance.
    typedef enum logic [1:0] {
        PH_LAST_UPDATE,
        PH_FIX_NOW,
        PH_REGULAR
    } pws_phase_t;

endpackage

// File: rtl/core/pws_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic window scheduler remainder unit
// Restoring bit-serial division that yields dividend mod divisor, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module pws_rem_unit #(
    parameter int TIME_BITS   = 40,
    parameter int PERIOD_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [TIME_BITS-1:0]   dividend,
    input  logic [PERIOD_BITS-1:0] divisor,
    output logic                   done,
    output logic [PERIOD_BITS-1:0] remainder
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [TIME_BITS-1:0]   shift_reg, shift_next;
    logic [PERIOD_BITS-1:0] rem_reg, rem_next;
    logic [PERIOD_BITS:0]   rem_shift;
    logic [PERIOD_BITS:0]   rem_diff;

    assign rem_shift = {rem_reg, shift_reg[TIME_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            cnt_next   = CNT_W'(TIME_BITS);
            shift_next = dividend;
            rem_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[TIME_BITS-2:0], 1'b0};
            // The partial remainder stays below the divisor, so the
            // difference always fits back into the remainder width.
            if (rem_shift >= {1'b0, divisor})
                rem_next = rem_diff[PERIOD_BITS-1:0];
            else
                rem_next = rem_shift[PERIOD_BITS-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/periodic_window_scheduler.sv
`timescale 1ns / 1ps
// A request is taken in the idle state, and its result loads into the output register
// from the done state, which waits while a held result is stalled. An advance runs the
// advance, divide, span and apply states; the first request may advance twice.
// One request at a time: a new request is taken only after the previous result loads,
// and the request side stalls while the bit-serial divider runs.
// Reset is asynchronous, active low; registers with a reset return to their reset values.
// ----------------------------------------------------------------------------
// Periodic window scheduler
// Moves a repeating start/stop window forward by whole periods and reports
// start, stop and resume events for each time request.
// ----------------------------------------------------------------------------
module periodic_window_scheduler
    import pws_pkg::*;
#(
    parameter int TIME_BITS   = 40,
    parameter int PERIOD_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [TIME_BITS-1:0]      now_seconds,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      resume_called,
    output logic                      stop_called,
    output logic                      start_called,
    output logic [1:0]                change_events,
    output logic                      active,
    output logic [TIME_BITS:0]        next_start,
    output logic [TIME_BITS:0]        next_stop
);

    localparam int WIN_BITS = TIME_BITS + 1;

    // Configuration registers.
    logic [PERIOD_BITS-1:0] period_cfg_reg;
    logic [TIME_BITS-1:0]   first_start_reg;
    logic [TIME_BITS-1:0]   first_stop_reg;
    logic [TIME_BITS-1:0]   last_update_reg;
    logic                   was_running_reg;

    pws_state_t state_reg, state_next;
    pws_phase_t phase_reg, phase_next;

    logic [PERIOD_BITS-1:0] held_period_reg, held_period_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TIME_BITS-1:0]   ref_reg, ref_next;
    logic [TIME_BITS-1:0]   d_reg, d_next;
    logic [WIN_BITS-1:0]    span_reg, span_next;
    logic [WIN_BITS-1:0]    win_start_reg, win_start_next;
    logic [WIN_BITS-1:0]    win_stop_reg, win_stop_next;
    logic                   running_reg, running_next;
    logic                   fixup_reg, fixup_next;
    logic                   resume_f_reg, resume_f_next;
    logic                   stop_f_reg, stop_f_next;
    logic                   start_f_reg, start_f_next;
    logic [1:0]             events_reg, events_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_resume_reg, out_stop_reg, out_start_reg, out_active_reg;
    logic [1:0]             out_events_reg;
    logic [WIN_BITS-1:0]    out_start_time_reg, out_stop_time_reg;
    logic                   out_load;

    logic                   div_start;
    logic                   div_done;
    logic [PERIOD_BITS-1:0] div_rem;
    logic [TIME_BITS-1:0]   adv_dist;
    logic [WIN_BITS:0]      start_sum;
    logic                   now_ge_stop;
    logic                   now_ge_start;
    logic                   ref_ge_stop;
    pws_state_t             adv_return;

    assign now_ge_stop  = {1'b0, now_reg} >= win_stop_reg;
    assign now_ge_start = {1'b0, now_reg} >= win_start_reg;
    assign ref_ge_stop  = {1'b0, ref_reg} >= win_stop_reg;
    assign adv_dist     = ref_reg - win_stop_reg[TIME_BITS-1:0];
    assign start_sum    = {1'b0, win_start_reg} + {1'b0, span_reg};

    always_comb
    begin
        unique case (phase_reg)
            PH_LAST_UPDATE: adv_return = ST_FIX_NOW;
            PH_FIX_NOW:     adv_return = ST_FIX_START;
            PH_REGULAR:     adv_return = ST_REG_START;
            default:        adv_return = ST_REG_START;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_cfg_reg  <= PERIOD_BITS'(1);
            first_start_reg <= '0;
            first_stop_reg  <= TIME_BITS'(1);
            last_update_reg <= '0;
            was_running_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD:      period_cfg_reg  <= cfg_data[PERIOD_BITS-1:0];
                CFG_FIRST_START: first_start_reg <= cfg_data;
                CFG_FIRST_STOP:  first_stop_reg  <= cfg_data;
                CFG_LAST_UPDATE: last_update_reg <= cfg_data;
                CFG_WAS_RUNNING: was_running_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    pws_rem_unit #(
        .TIME_BITS   (TIME_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (adv_dist),
        .divisor   (held_period_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        held_period_next = held_period_reg;
        now_next         = now_reg;
        ref_next         = ref_reg;
        d_next           = d_reg;
        span_next        = span_reg;
        win_start_next   = win_start_reg;
        win_stop_next    = win_stop_reg;
        running_next     = running_reg;
        fixup_next       = fixup_reg;
        resume_f_next    = resume_f_reg;
        stop_f_next      = stop_f_reg;
        start_f_next     = start_f_reg;
        events_next      = events_reg;
        div_start        = 1'b0;
        out_load         = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next      = now_seconds;
                    resume_f_next = 1'b0;
                    stop_f_next   = 1'b0;
                    start_f_next  = 1'b0;
                    events_next   = 2'd0;
                    state_next    = fixup_reg ? ST_FIX_INIT : ST_REG_STOP;
                end
            end
            ST_FIX_INIT:
            begin
                held_period_next = (period_cfg_reg == '0) ? PERIOD_BITS'(1) : period_cfg_reg;
                win_start_next   = {1'b0, first_start_reg};
                win_stop_next    = {1'b0, first_stop_reg};
                running_next     = was_running_reg;
                ref_next         = last_update_reg;
                phase_next       = PH_LAST_UPDATE;
                state_next       = ST_ADV;
            end
            ST_ADV:
            begin
                if (ref_ge_stop)
                begin
                    d_next     = adv_dist;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = adv_return;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                // Whole periods past the reference: d - (d mod p) + p.
                span_next  = {1'b0, d_reg} - WIN_BITS'(div_rem) + WIN_BITS'(held_period_reg);
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                win_stop_next  = win_stop_reg + span_reg;
                win_start_next = start_sum[WIN_BITS] ? '1 : start_sum[WIN_BITS-1:0];
                state_next     = adv_return;
            end
            ST_FIX_NOW:
            begin
                events_next = 2'd1;
                fixup_next  = 1'b0;
                if (now_ge_stop)
                begin
                    if (running_reg)
                    begin
                        resume_f_next = 1'b1;
                        stop_f_next   = 1'b1;
                        running_next  = 1'b0;
                    end
                    ref_next   = now_reg;
                    phase_next = PH_FIX_NOW;
                    state_next = ST_ADV;
                end
                else
                begin
                    if (now_ge_start)
                    begin
                        if (running_reg)
                            resume_f_next = 1'b1;
                        else
                            start_f_next = 1'b1;
                        running_next = 1'b1;
                    end
                    state_next = ST_REG_STOP;
                end
            end
            ST_FIX_START:
            begin
                if (now_ge_start)
                begin
                    start_f_next = 1'b1;
                    running_next = 1'b1;
                end
                state_next = ST_REG_STOP;
            end
            ST_REG_STOP:
            begin
                if (running_reg && now_ge_stop)
                begin
                    stop_f_next  = 1'b1;
                    running_next = 1'b0;
                    events_next  = events_reg + 2'd1;
                    ref_next     = now_reg;
                    phase_next   = PH_REGULAR;
                    state_next   = ST_ADV;
                end
                else
                begin
                    state_next = ST_REG_START;
                end
            end
            ST_REG_START:
            begin
                if (!running_reg && now_ge_start)
                begin
                    start_f_next = 1'b1;
                    running_next = 1'b1;
                    events_next  = events_reg + 2'd1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_LAST_UPDATE;
            held_period_reg <= PERIOD_BITS'(1);
            win_start_reg   <= '0;
            win_stop_reg    <= '0;
            running_reg     <= 1'b0;
            fixup_reg       <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            held_period_reg <= held_period_next;
            win_start_reg   <= win_start_next;
            win_stop_reg    <= win_stop_next;
            running_reg     <= running_next;
            fixup_reg       <= fixup_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        ref_reg      <= ref_next;
        d_reg        <= d_next;
        span_reg     <= span_next;
        resume_f_reg <= resume_f_next;
        stop_f_reg   <= stop_f_next;
        start_f_reg  <= start_f_next;
        events_reg   <= events_next;
        if (out_load)
        begin
            out_resume_reg     <= resume_f_reg;
            out_stop_reg       <= stop_f_reg;
            out_start_reg      <= start_f_reg;
            out_events_reg     <= events_reg;
            out_active_reg     <= running_reg;
            out_start_time_reg <= win_start_reg;
            out_stop_time_reg  <= win_stop_reg;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign resume_called = out_resume_reg;
    assign stop_called   = out_stop_reg;
    assign start_called  = out_start_reg;
    assign change_events = out_events_reg;
    assign active        = out_active_reg;
    assign next_start    = out_start_time_reg;
    assign next_stop     = out_stop_time_reg;

endmodule

// File: rtl/core/pws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic window scheduler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_window_scheduler_macros.svh"

module pws_checker #(
    parameter int TIME_BITS = 40
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               resume_called,
    input logic               stop_called,
    input logic               start_called,
    input logic [1:0]         change_events,
    input logic               active,
    input logic [TIME_BITS:0] next_start,
    input logic [TIME_BITS:0] next_stop
);

    // A stalled result holds its contents.
    `PWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(next_start) && $stable(next_stop) && $stable(change_events), "stalled result changed")

    // A fresh start always leaves the window running.
    `PWS_ASSERT_SAME(a_start_active, out_valid && start_called, active, "start reported but window not active")

    // A resume only comes from the set-up pass, which counts exactly one event.
    `PWS_ASSERT_SAME(a_resume_events, out_valid && resume_called, change_events == 2'd1, "resume with wrong event count")

    // Without any report, at most the set-up event is counted.
    `PWS_ASSERT_SAME(a_quiet_events, out_valid && !resume_called && !stop_called && !start_called, change_events == 2'd0 || change_events == 2'd1, "events counted without report")

endmodule

bind periodic_window_scheduler pws_checker #(
    .TIME_BITS (TIME_BITS)
) u_pws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .resume_called (resume_called),
    .stop_called   (stop_called),
    .start_called  (start_called),
    .change_events (change_events),
    .active        (active),
    .next_start    (next_start),
    .next_stop     (next_stop)
);

// File: tb/sv/periodic_window_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic window scheduler checker
// Watches the configuration port and the request and result channels, keeps its own
// copy of the window state, and compares every result field by field against
// the oldest predicted report.
// ----------------------------------------------------------------------------
module periodic_window_scheduler_checker
    import pws_pkg::*;
#(
    parameter int TIME_BITS   = 40,
    parameter int PERIOD_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]      cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [TIME_BITS-1:0]      now_seconds,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      resume_called,
    input  logic                      stop_called,
    input  logic                      start_called,
    input  logic [1:0]                change_events,
    input  logic                      active,
    input  logic [TIME_BITS:0]        next_start,
    input  logic [TIME_BITS:0]        next_stop,
    output int                        mismatch_count,
    output int                        outstanding,
    output int                        start_count,
    output int                        stop_count
);

    localparam logic [63:0] WIN_MAX = (64'd1 << (TIME_BITS + 1)) - 64'd1;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic                 resume;
        logic                 stop;
        logic                 start;
        logic [1:0]           events;
        logic                 act;
        logic [TIME_BITS:0]   nstart;
        logic [TIME_BITS:0]   nstop;
    } window_report_t;

    // Register copies, written through the configuration port.
    logic [PERIOD_BITS-1:0] reg_period;
    logic [TIME_BITS-1:0]   reg_first_start;
    logic [TIME_BITS-1:0]   reg_first_stop;
    logic [TIME_BITS-1:0]   reg_last_update;
    logic                   reg_was_running;

    // Window state, latched from the registers on the first request.
    logic [63:0] held_period;
    logic [63:0] win_start;
    logic [63:0] win_stop;
    logic        running;
    logic        fixup_pending;

    window_report_t expected_reports[$];
    int err_total;
    int results_checked;
    int starts_seen;
    int stops_seen;

    function automatic void move_past(input logic [63:0] ref_time);
        logic [63:0] span;
        logic [63:0] moved;
        if (ref_time < win_stop)
            return;
        span = ((ref_time - win_stop) / held_period + 64'd1) * held_period;
        win_stop = win_stop + span;
        moved = win_start + span;
        win_start = (moved > WIN_MAX) ? WIN_MAX : moved;
    endfunction

    function automatic window_report_t predict_report(input logic [TIME_BITS-1:0] now_in);
        window_report_t rep;
        logic [63:0] now;
        now = 64'(now_in);
        rep = '0;
        if (fixup_pending)
        begin
            held_period = (reg_period == '0) ? 64'd1 : 64'(reg_period);
            win_start = 64'(reg_first_start);
            win_stop = 64'(reg_first_stop);
            move_past(64'(reg_last_update));
            running = reg_was_running;
            // Catch-up pass: a window that was live at take-over is resumed
            // or closed before the current time is considered.
            if (now >= win_stop)
            begin
                if (running)
                begin
                    rep.resume = 1'b1;
                    rep.stop = 1'b1;
                    running = 1'b0;
                end
                move_past(now);
                if (now >= win_start)
                begin
                    rep.start = 1'b1;
                    running = 1'b1;
                end
            end
            else if (now >= win_start)
            begin
                if (running)
                    rep.resume = 1'b1;
                else
                    rep.start = 1'b1;
                running = 1'b1;
            end
            rep.events = rep.events + 2'd1;
            fixup_pending = 1'b0;
        end
        if (running && now >= win_stop)
        begin
            rep.stop = 1'b1;
            move_past(now);
            running = 1'b0;
            rep.events = rep.events + 2'd1;
        end
        if (!running && now >= win_start)
        begin
            rep.start = 1'b1;
            running = 1'b1;
            rep.events = rep.events + 2'd1;
        end
        rep.act = running;
        rep.nstart = win_start[TIME_BITS:0];
        rep.nstop = win_stop[TIME_BITS:0];
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_total++;
        if (err_total <= PRINT_CAP)
            $display("%0t mismatch on result %0d, %s: got %0h, expected %0h",
                     $time, results_checked, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_report_t want;
        if (!rst_n)
        begin
            reg_period = PERIOD_BITS'(1);
            reg_first_start = '0;
            reg_first_stop = TIME_BITS'(1);
            reg_last_update = '0;
            reg_was_running = 1'b0;
            held_period = 64'd1;
            win_start = '0;
            win_stop = '0;
            running = 1'b0;
            fixup_pending = 1'b1;
            expected_reports.delete();
            err_total = 0;
            results_checked = 0;
            starts_seen = 0;
            stops_seen = 0;
            mismatch_count <= 0;
            outstanding <= 0;
            start_count <= 0;
            stop_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                starts_seen += int'(start_called === 1'b1);
                stops_seen += int'(stop_called === 1'b1);
                if (expected_reports.size() == 0)
                begin
                    report_mismatch("result with no request pending", 64'd1, 64'd0);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (resume_called !== want.resume)
                        report_mismatch("resume_called", 64'(resume_called),
                                        64'(want.resume));
                    if (stop_called !== want.stop)
                        report_mismatch("stop_called", 64'(stop_called), 64'(want.stop));
                    if (start_called !== want.start)
                        report_mismatch("start_called", 64'(start_called),
                                        64'(want.start));
                    if (change_events !== want.events)
                        report_mismatch("change_events", 64'(change_events),
                                        64'(want.events));
                    if (active !== want.act)
                        report_mismatch("active", 64'(active), 64'(want.act));
                    if (next_start !== want.nstart)
                        report_mismatch("next_start", 64'(next_start), 64'(want.nstart));
                    if (next_stop !== want.nstop)
                        report_mismatch("next_stop", 64'(next_stop), 64'(want.nstop));
                end
                results_checked++;
            end
            if (in_valid && !in_stall)
                expected_reports.push_back(predict_report(now_seconds));
            // Writes after the first request are stored but never latched.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD:      reg_period = cfg_data[PERIOD_BITS-1:0];
                    CFG_FIRST_START: reg_first_start = cfg_data;
                    CFG_FIRST_STOP:  reg_first_stop = cfg_data;
                    CFG_LAST_UPDATE: reg_last_update = cfg_data;
                    CFG_WAS_RUNNING: reg_was_running = cfg_data[0];
                    default: ;
                endcase
            end
            mismatch_count <= err_total;
            outstanding <= expected_reports.size();
            start_count <= starts_seen;
            stop_count <= stops_seen;
        end
    end

endmodule

// File: tb/sv/tb_periodic_window_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic window scheduler testbench
// Sets up one window configuration after reset, then sends time requests that
// creep, hold, step back, jump ahead and land on window edges, with random
// gaps and result stalls. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_periodic_window_scheduler;
    import pws_pkg::*;

    localparam int TIME_BITS      = 40;
    localparam int PERIOD_BITS    = 24;
    localparam logic [63:0] TIME_MAX   = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [63:0] PERIOD_MAX = (64'd1 << PERIOD_BITS) - 64'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 420;

    typedef enum {
        STEP_CREEP,
        STEP_EDGE,
        STEP_HOLD,
        STEP_BACK,
        STEP_ZERO,
        STEP_NOISE,
        STEP_LEAP
    } step_kind_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TIME_BITS-1:0]      cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [TIME_BITS-1:0]      now_seconds = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      resume_called;
    logic                      stop_called;
    logic                      start_called;
    logic [1:0]                change_events;
    logic                      active;
    logic [TIME_BITS:0]        next_start;
    logic [TIME_BITS:0]        next_stop;

    int mismatch_count;
    int outstanding;
    int start_count;
    int stop_count;

    logic [63:0] eff_period;
    logic [63:0] anchor_start;
    logic [63:0] anchor_stop;
    logic [63:0] cursor;
    logic        overflow_run = 1'b0;
    logic        calm = 1'b0;
    int          items_sent = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    periodic_window_scheduler dut (.*);

    periodic_window_scheduler_checker checker_i (.*);

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Result side back-pressure.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 2) == 0)
        begin
            stall_left <= gap_len();
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic step_kind_t choose_kind();
        int r;
        r = $urandom_range(0, 99);
        if (overflow_run && r < 50)
            return STEP_NOISE;
        if (r < 54)
            return STEP_CREEP;
        if (r < 75)
            return STEP_EDGE;
        if (r < 83)
            return STEP_HOLD;
        if (r < 90)
            return STEP_BACK;
        if (r < 91)
            return STEP_ZERO;
        if (r < 96)
            return STEP_NOISE;
        return STEP_LEAP;
    endfunction

    // Picks the next request time; the cursor is the reference time that forward steps advance.
    function automatic logic [63:0] next_time(input step_kind_t kind);
        logic [63:0] t;
        logic [63:0] anchor;
        logic [63:0] target;
        logic [63:0] back;
        int off;
        t = cursor;
        case (kind)
            STEP_CREEP: cursor = cursor + 64'($urandom_range(0, 32'(eff_period)));
            STEP_EDGE:
            begin
                // Window edges sit at whole periods from the initial start and stop.
                anchor = $urandom_range(0, 1) ? anchor_stop : anchor_start;
                if (cursor < anchor)
                    target = anchor;
                else
                    target = anchor + ((cursor - anchor) / eff_period + 64'd1) * eff_period;
                off = $urandom_range(0, 2);
                if (off == 0 && target != 0)
                    target = target - 64'd1;
                else if (off == 2)
                    target = target + 64'd1;
                if (target > cursor)
                    cursor = target;
                t = target;
            end
            STEP_HOLD: ;
            STEP_BACK:
            begin
                back = 64'($urandom_range(1, 32'(3 * eff_period)));
                t = (back > cursor) ? 64'd0 : cursor - back;
            end
            STEP_ZERO: t = 64'd0;
            STEP_NOISE:
            begin
                t = {$urandom, $urandom} & TIME_MAX;
                if (!overflow_run)
                    t = t % (cursor + 64'd1);
            end
            STEP_LEAP: cursor = cursor + 64'($urandom_range(2, 1000)) * eff_period
                                + 64'($urandom_range(0, 32'(eff_period)));
            default: ;
        endcase
        if (cursor > TIME_MAX)
            cursor = TIME_MAX;
        if (kind == STEP_CREEP || kind == STEP_LEAP || kind == STEP_HOLD)
            t = cursor;
        if (t > TIME_MAX)
            t = TIME_MAX;
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[TIME_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic write_extremes();
        write_reg(CFG_UNMAPPED, TIME_MAX);
        write_reg(CFG_PERIOD, 64'd0);
        write_reg(CFG_PERIOD, TIME_MAX);
        write_reg(CFG_FIRST_START, TIME_MAX);
        write_reg(CFG_FIRST_START, 64'd0);
        write_reg(CFG_FIRST_STOP, 64'd0);
        write_reg(CFG_FIRST_STOP, TIME_MAX);
        write_reg(CFG_LAST_UPDATE, TIME_MAX);
        write_reg(CFG_LAST_UPDATE, 64'd0);
        write_reg(CFG_WAS_RUNNING, TIME_MAX);
        write_reg(CFG_WAS_RUNNING, 64'd0);
    endtask

    task automatic send_time(input logic [63:0] t);
        int gap;
        gap = calm ? 0 : gap_len();
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_seconds <= t[TIME_BITS-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sel;
        int ph;
        int n;
        logic [63:0] period_word;
        logic [63:0] update_word;
        logic [63:0] base;
        step_kind_t opening[19];

        sel = $urandom_range(0, 9);
        overflow_run = (sel == 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Only one reset per run, so the last values written before the first
        // request decide the single window setup this run exercises.
        write_extremes();
        if (overflow_run)
        begin
            // Start far beyond stop: the catch-up pushes the start past the top.
            period_word = PERIOD_MAX;
            anchor_start = TIME_MAX;
            anchor_stop = 64'd0;
            update_word = TIME_MAX;
            cursor = {$urandom, $urandom} & TIME_MAX;
        end
        else
        begin
            if (sel <= 2)
                period_word = 64'd0;
            else if (sel == 3)
                period_word = PERIOD_MAX;
            else
                period_word = 64'($urandom_range(1, 3000));
            eff_period = (period_word == 0) ? 64'd1 : period_word;
            base = 64'($urandom_range(0, 4000));
            anchor_start = base + 64'($urandom_range(0, 32'(2 * eff_period)));
            case ($urandom_range(0, 3))
                0: anchor_stop = anchor_start;
                1: anchor_stop = anchor_start - ((anchor_start < eff_period) ?
                                 anchor_start : 64'($urandom_range(1, 32'(eff_period))));
                default: anchor_stop = anchor_start
                                       + 64'($urandom_range(1, 32'(eff_period)));
            endcase
            update_word = base + 64'($urandom_range(0, 32'(4 * eff_period)));
            cursor = base + 64'($urandom_range(0, 32'(6 * eff_period)));
        end
        eff_period = (period_word == 0) ? 64'd1 : period_word;
        write_reg(CFG_PERIOD, period_word);
        write_reg(CFG_FIRST_START, anchor_start);
        write_reg(CFG_FIRST_STOP, anchor_stop);
        write_reg(CFG_LAST_UPDATE, update_word);
        write_reg(CFG_WAS_RUNNING, 64'($urandom_range(0, 1)));
        write_reg(CFG_UNMAPPED, TIME_MAX);

        // The first request runs the catch-up pass.
        send_time(cursor);
        opening = '{STEP_HOLD, STEP_EDGE, STEP_EDGE, STEP_EDGE, STEP_CREEP, STEP_EDGE,
                    STEP_EDGE, STEP_CREEP, STEP_BACK, STEP_ZERO, STEP_HOLD, STEP_EDGE,
                    STEP_LEAP, STEP_EDGE, STEP_EDGE, STEP_NOISE, STEP_CREEP, STEP_EDGE,
                    STEP_HOLD};
        foreach (opening[i])
            send_time(next_time(opening[i]));

        // Registers written now are kept but must not disturb the window.
        drain_results();
        write_extremes();

        for (ph = 0; ph < PHASES; ph++)
        begin
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 60 == 0)
                    calm <= ($urandom_range(0, 3) == 0);
                // Finish near the top of the time range so the high bits toggle.
                if (ph == PHASES - 1 && n == PHASE_ITEMS - 40)
                    cursor = TIME_MAX - 64'($urandom_range(0, 30)) * eff_period;
                send_time(next_time(choose_kind()));
            end
            if (ph != PHASES - 1)
            begin
                drain_results();
                write_extremes();
            end
        end
        send_time(TIME_MAX);
        drain_results();

        $display("Sent %0d time requests, period %0d, %s, initial start %0h, stop %0h.",
                 items_sent, eff_period, overflow_run ? "saturating start setup" :
                 "regular setup", anchor_start, anchor_stop);
        $display("Block reported %0d window starts and %0d stops; %0d mismatches.",
                 start_count, stop_count, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
